// File: sv/calu_pkg.sv
// Shared types and constants for the 8-bit ALU with flags.
// Holds the command codes, the flag bit positions and the item structs.
// No dependencies; imported by calu_core and cpu_alu_with_flags.
package calu_pkg;

   localparam int CMD_W  = 5;
   localparam int BYTE_W = 8;
   localparam int WORD_W = 16;
   localparam int FLAG_W = 4;

   // Flag bit positions
   localparam int FLAG_Z = 3;
   localparam int FLAG_N = 2;
   localparam int FLAG_H = 1;
   localparam int FLAG_C = 0;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_ADD   = 5'd0;
   localparam logic [CMD_W-1:0] CMD_ADC   = 5'd1;
   localparam logic [CMD_W-1:0] CMD_SUB   = 5'd2;
   localparam logic [CMD_W-1:0] CMD_SBC   = 5'd3;
   localparam logic [CMD_W-1:0] CMD_AND   = 5'd4;
   localparam logic [CMD_W-1:0] CMD_XOR   = 5'd5;
   localparam logic [CMD_W-1:0] CMD_OR    = 5'd6;
   localparam logic [CMD_W-1:0] CMD_CP    = 5'd7;
   localparam logic [CMD_W-1:0] CMD_INC8  = 5'd8;
   localparam logic [CMD_W-1:0] CMD_DEC8  = 5'd9;
   localparam logic [CMD_W-1:0] CMD_RLCA  = 5'd10;
   localparam logic [CMD_W-1:0] CMD_RLA   = 5'd11;
   localparam logic [CMD_W-1:0] CMD_RRCA  = 5'd12;
   localparam logic [CMD_W-1:0] CMD_RRA   = 5'd13;
   localparam logic [CMD_W-1:0] CMD_DAA   = 5'd14;
   localparam logic [CMD_W-1:0] CMD_CPL   = 5'd15;
   localparam logic [CMD_W-1:0] CMD_CCF   = 5'd16;
   localparam logic [CMD_W-1:0] CMD_SCF   = 5'd17;
   localparam logic [CMD_W-1:0] CMD_ADD16 = 5'd18;
   localparam logic [CMD_W-1:0] CMD_ADDSP = 5'd19;
   localparam logic [CMD_W-1:0] CMD_INC16 = 5'd20;
   localparam logic [CMD_W-1:0] CMD_DEC16 = 5'd21;
   localparam logic [CMD_W-1:0] CMD_LDF   = 5'd22;

   // BCD correction constants and the LDF flag mask
   localparam logic [BYTE_W-1:0] DAA_LO_CORR = 8'h06;
   localparam logic [BYTE_W-1:0] DAA_HI_CORR = 8'h60;
   localparam logic [BYTE_W-1:0] DAA_HI_LIM  = 8'h99;
   localparam logic [BYTE_W-1:0] LDF_MASK    = 8'hF0;

   // One input item
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [BYTE_W-1:0] acc;
      logic [BYTE_W-1:0] operand;
      logic [WORD_W-1:0] wide_a;
      logic [WORD_W-1:0] wide_b;
   } alu_req_type;

   // One result item
   typedef struct packed {
      logic [WORD_W-1:0] result;
      logic [FLAG_W-1:0] flags;
   } alu_rsp_type;

endpackage

// File: sv/calu_core.sv
// Combinational datapath of the 8-bit ALU: result and new flags for one item.
// Depends on calu_pkg for command codes, flag positions and item structs.
module calu_core (
   input  calu_pkg::alu_req_type         op,
   input  logic [calu_pkg::FLAG_W-1:0]   flags_cur,
   output calu_pkg::alu_rsp_type         rsp
);
   import calu_pkg::*;

   logic              zf, nf, hf, cf;
   logic              cin_adc, cin_sbc;
   logic [BYTE_W:0]   sum9, diff9;
   logic [4:0]        sum_lo, diff_lo;
   logic [BYTE_W-1:0] inc8, dec8;
   logic [BYTE_W-1:0] daa_corr, daa_res;
   logic              daa_cout;
   logic [WORD_W:0]   sum17;
   logic [12:0]       sum13;
   logic [WORD_W-1:0] sp_sum;
   logic [4:0]        sp_lo;
   logic [BYTE_W:0]   sp_byte;

   assign zf = flags_cur[FLAG_Z];
   assign nf = flags_cur[FLAG_N];
   assign hf = flags_cur[FLAG_H];
   assign cf = flags_cur[FLAG_C];

   // Carry in only for the with-carry forms
   assign cin_adc = (op.cmd == CMD_ADC) ? cf : 1'b0;
   assign cin_sbc = (op.cmd == CMD_SBC) ? cf : 1'b0;

   // 8-bit add and subtract with nibble carries; bit 8 / bit 4 is carry or borrow
   assign sum9    = {1'b0, op.acc} + {1'b0, op.operand} + {8'd0, cin_adc};
   assign sum_lo  = {1'b0, op.acc[3:0]} + {1'b0, op.operand[3:0]} + {4'd0, cin_adc};
   assign diff9   = {1'b0, op.acc} - {1'b0, op.operand} - {8'd0, cin_sbc};
   assign diff_lo = {1'b0, op.acc[3:0]} - {1'b0, op.operand[3:0]} - {4'd0, cin_sbc};

   assign inc8 = op.acc + 8'd1;
   assign dec8 = op.acc - 8'd1;

   // Decimal adjust
   always_comb begin
      daa_corr = '0;
      daa_cout = cf;
      if (hf || (!nf && (op.acc[3:0] > 4'd9))) begin
         daa_corr = daa_corr | DAA_LO_CORR;
      end
      if (cf || (!nf && (op.acc > DAA_HI_LIM))) begin
         daa_corr = daa_corr | DAA_HI_CORR;
         daa_cout = 1'b1;
      end
   end
   assign daa_res = nf ? (op.acc - daa_corr) : (op.acc + daa_corr);

   // 16-bit add: H out of bit 11, C out of bit 15
   assign sum17 = {1'b0, op.wide_a} + {1'b0, op.wide_b};
   assign sum13 = {1'b0, op.wide_a[11:0]} + {1'b0, op.wide_b[11:0]};

   // Stack pointer plus signed offset; flags from the unsigned low byte add
   assign sp_sum  = op.wide_a + {{(WORD_W-BYTE_W){op.operand[BYTE_W-1]}}, op.operand};
   assign sp_lo   = {1'b0, op.wide_a[3:0]} + {1'b0, op.operand[3:0]};
   assign sp_byte = {1'b0, op.wide_a[7:0]} + {1'b0, op.operand};

   // Result and flag select
   always_comb begin
      rsp.result = '0;
      rsp.flags  = flags_cur;
      unique case (op.cmd)
         CMD_ADD, CMD_ADC: begin
            rsp.result = {8'd0, sum9[BYTE_W-1:0]};
            rsp.flags  = {(sum9[BYTE_W-1:0] == 8'd0), 1'b0, sum_lo[4], sum9[BYTE_W]};
         end
         CMD_SUB, CMD_SBC, CMD_CP: begin
            rsp.result = (op.cmd == CMD_CP) ? {8'd0, op.acc} : {8'd0, diff9[BYTE_W-1:0]};
            rsp.flags  = {(diff9[BYTE_W-1:0] == 8'd0), 1'b1, diff_lo[4], diff9[BYTE_W]};
         end
         CMD_AND: begin
            rsp.result = {8'd0, op.acc & op.operand};
            rsp.flags  = {((op.acc & op.operand) == 8'd0), 1'b0, 1'b1, 1'b0};
         end
         CMD_XOR: begin
            rsp.result = {8'd0, op.acc ^ op.operand};
            rsp.flags  = {((op.acc ^ op.operand) == 8'd0), 3'b000};
         end
         CMD_OR: begin
            rsp.result = {8'd0, op.acc | op.operand};
            rsp.flags  = {((op.acc | op.operand) == 8'd0), 3'b000};
         end
         CMD_INC8: begin
            rsp.result = {8'd0, inc8};
            rsp.flags  = {(inc8 == 8'd0), 1'b0, (op.acc[3:0] == 4'hF), cf};
         end
         CMD_DEC8: begin
            rsp.result = {8'd0, dec8};
            rsp.flags  = {(dec8 == 8'd0), 1'b1, (op.acc[3:0] == 4'h0), cf};
         end
         CMD_RLCA: begin
            rsp.result = {8'd0, op.acc[6:0], op.acc[7]};
            rsp.flags  = {3'b000, op.acc[7]};
         end
         CMD_RLA: begin
            rsp.result = {8'd0, op.acc[6:0], cf};
            rsp.flags  = {3'b000, op.acc[7]};
         end
         CMD_RRCA: begin
            rsp.result = {8'd0, op.acc[0], op.acc[7:1]};
            rsp.flags  = {3'b000, op.acc[0]};
         end
         CMD_RRA: begin
            rsp.result = {8'd0, cf, op.acc[7:1]};
            rsp.flags  = {3'b000, op.acc[0]};
         end
         CMD_DAA: begin
            rsp.result = {8'd0, daa_res};
            rsp.flags  = {(daa_res == 8'd0), nf, 1'b0, daa_cout};
         end
         CMD_CPL: begin
            rsp.result = {8'd0, ~op.acc};
            rsp.flags  = {zf, 1'b1, 1'b1, cf};
         end
         CMD_CCF: begin
            rsp.result = {8'd0, op.acc};
            rsp.flags  = {zf, 1'b0, 1'b0, ~cf};
         end
         CMD_SCF: begin
            rsp.result = {8'd0, op.acc};
            rsp.flags  = {zf, 1'b0, 1'b0, 1'b1};
         end
         CMD_ADD16: begin
            rsp.result = sum17[WORD_W-1:0];
            rsp.flags  = {zf, 1'b0, sum13[12], sum17[WORD_W]};
         end
         CMD_ADDSP: begin
            rsp.result = sp_sum;
            rsp.flags  = {1'b0, 1'b0, sp_lo[4], sp_byte[BYTE_W]};
         end
         CMD_INC16: begin
            rsp.result = op.wide_a + 16'd1;
         end
         CMD_DEC16: begin
            rsp.result = op.wide_a - 16'd1;
         end
         CMD_LDF: begin
            rsp.result = {8'd0, op.operand & LDF_MASK};
            rsp.flags  = op.operand[7:4];
         end
         default: begin
            // unused codes: zero result, flags kept
            rsp.result = '0;
            rsp.flags  = flags_cur;
         end
      endcase
   end

endmodule

// File: sv/cpu_alu_with_flags.sv
// 8-bit ALU with Z/N/H/C flag register: top level with input and result registers.
// Depends on calu_pkg and calu_core.
//
// Usage: an item on the req_ channel carries a command code and its operands
// (req_acc, req_operand, req_wide_a, req_wide_b). Exactly one item comes back
// on the rsp_ channel for each one taken: rsp_result and rsp_flags_out.
// Both channels use valid/ready; an item moves when both are high.
// Path: an accepted item goes into the input register, then through the
// single-level ALU into the result register, which drives rsp_valid.
// Throughput: one item per cycle while rsp_ready stays high, set by the flag
// register loop, which feeds each item's flags into the next through the ALU.
// Stall: while the result waits, one more item is still taken into the
// input register; after that req_ready drops until rsp_ready returns.
// Reset: synchronous, active high; empties both registers and clears the
// flag register to zero.
module cpu_alu_with_flags (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [calu_pkg::CMD_W-1:0]      req_cmd,
   input  logic [calu_pkg::BYTE_W-1:0]     req_acc,
   input  logic [calu_pkg::BYTE_W-1:0]     req_operand,
   input  logic [calu_pkg::WORD_W-1:0]     req_wide_a,
   input  logic [calu_pkg::WORD_W-1:0]     req_wide_b,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [calu_pkg::WORD_W-1:0]     rsp_result,
   output logic [calu_pkg::FLAG_W-1:0]     rsp_flags_out
);
   import calu_pkg::*;

   alu_req_type       in_ff, in_in;
   logic              in_vld_ff, in_vld_in;
   alu_rsp_type       out_ff, out_in;
   logic              out_vld_ff, out_vld_in;
   logic [FLAG_W-1:0] flag_ff, flag_in;
   alu_rsp_type       alu_rsp;
   logic              advance;
   logic              req_take;

   // ALU datapath
   calu_core u_core (
      .op        (in_ff),
      .flags_cur (flag_ff),
      .rsp       (alu_rsp)
   );

   // Handshake: item moves to the result register when that slot frees
   assign advance   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign req_take  = req_valid && req_ready;

   // Next-state logic
   always_comb begin
      in_in      = in_ff;
      in_vld_in  = in_vld_ff;
      out_in     = out_ff;
      out_vld_in = out_vld_ff;
      flag_in    = flag_ff;
      if (out_vld_ff && rsp_ready) begin
         out_vld_in = 1'b0;
      end
      if (advance) begin
         out_in     = alu_rsp;
         out_vld_in = 1'b1;
         flag_in    = alu_rsp.flags;
         in_vld_in  = 1'b0;
      end
      if (req_take) begin
         in_in.cmd     = req_cmd;
         in_in.acc     = req_acc;
         in_in.operand = req_operand;
         in_in.wide_a  = req_wide_a;
         in_in.wide_b  = req_wide_b;
         in_vld_in     = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         flag_ff    <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         flag_ff    <= flag_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      out_ff <= out_in;
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_result    = out_ff.result;
   assign rsp_flags_out = out_ff.flags;

   // Flag register always follows the last result produced
   assert property (@(posedge clock) disable iff (reset)
      advance |=> (flag_ff == out_ff.flags))
      else $error("flag register out of step with result");

   // A held input item is not dropped
   assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !advance) |=> in_vld_ff)
      else $error("pending item lost");

   // Input only blocks when both stages are full and the result is stalled
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_vld_ff && out_vld_ff && !rsp_ready))
      else $error("req_ready low without backpressure");

   // Flags only change when an item passes through the ALU
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(flag_ff))
      else $error("flags changed without an item");

endmodule
